// ----- design/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every other file refers to it by scoped names.
package wsd_pkg;

  localparam int BYTE_W     = 8;
  localparam int LIMIT_W    = 4;
  localparam int FNUM_W     = 4;
  localparam int LEN_W      = 64;
  localparam int LEN_CNT_W  = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // First header byte codes checked at packet start
  localparam logic [BYTE_W-1:0] OPC_TEXT  = 8'h81;
  localparam logic [BYTE_W-1:0] OPC_CLOSE = 8'h88;

  // Length byte codes (low 7 bits)
  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;

  localparam logic [LEN_CNT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [LEN_CNT_W-1:0] EXT64_BYTES = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNMASK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 8'd1;

  localparam logic             UNMASK_RST = 1'b1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd5;

  typedef enum logic [2:0] {
    EV_DATA  = 3'd0,
    EV_EMPTY = 3'd1,
    EV_CLOSE = 3'd2,
    EV_ERROR = 3'd3,
    EV_TRUNC = 3'd4
  } event_t;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_MASK = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

endpackage

// ----- design/wsd_ifs.sv -----
// Valid/ready channel interfaces for the deframer: byte input, result
// output and configuration write. Depends on wsd_pkg.
interface wsd_in_if;
  logic                      valid;
  logic                      ready;
  logic [wsd_pkg::BYTE_W-1:0] byte_in;
  logic                      packet_end;

  modport source (output valid, output byte_in, output packet_end, input ready);
  modport sink   (input valid, input byte_in, input packet_end, output ready);
endinterface

interface wsd_out_if;
  logic                       valid;
  logic                       ready;
  logic [wsd_pkg::BYTE_W-1:0]  out_byte;
  wsd_pkg::event_t            event_res;
  logic                       frame_last;
  logic [wsd_pkg::FNUM_W-1:0]  frame_number;

  modport source (output valid, output out_byte, output event_res, output frame_last,
                  output frame_number, input ready);
  modport sink   (input valid, input out_byte, input event_res, input frame_last,
                  input frame_number, output ready);
endinterface

interface wsd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wsd_pkg::CFG_IDX_W-1:0]  index;
  logic [wsd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/websocket_frame_deframer_core.sv -----
// WebSocket frame deframer top level; depends on wsd_pkg and wsd_ifs.
// A result is loaded into the output register on the clock edge of its byte transfer.
// Throughput: 1 byte per cycle while the output is not stalled; the byte parser is one step of header/XOR logic.
// Input ready drops only while a result is held and the output is stalled.
// Reset: synchronous, active low; unmask on, frame limit 5, parser at packet start.
// Configuration writes are always taken (cfg ready is tied high).
module websocket_frame_deframer_core (
  input  logic               clk,
  input  logic               rst_n,
  wsd_in_if.sink             in_s,
  wsd_out_if.source          out_m,
  wsd_cfg_if.sink            cfg_s
);

  // Configuration registers
  logic                         unmask_r;
  logic [wsd_pkg::LIMIT_W-1:0]  frame_limit_r;

  // Parser state
  wsd_pkg::phase_t                phase_r, phase_nxt;
  logic                           packet_start_r, packet_start_nxt;
  logic [wsd_pkg::LEN_CNT_W-1:0]  len_left_r, len_left_nxt;
  logic [wsd_pkg::LEN_W-1:0]      payload_left_r, payload_left_nxt;
  logic [31:0]                    mask_word_r, mask_word_nxt;
  logic [1:0]                     mask_cnt_r, mask_cnt_nxt;
  logic [1:0]                     mask_pos_r, mask_pos_nxt;
  logic [wsd_pkg::FNUM_W-1:0]     frames_seen_r, frames_seen_nxt;
  logic                           discarding_r, discarding_nxt;

  // Output register
  logic                          out_valid_r;
  logic [wsd_pkg::BYTE_W-1:0]    out_byte_r;
  wsd_pkg::event_t               out_event_r;
  logic                          out_last_r;
  logic [wsd_pkg::FNUM_W-1:0]    out_fnum_r;

  // Result of the current byte
  logic                          res_vld;
  logic [wsd_pkg::BYTE_W-1:0]    res_byte;
  wsd_pkg::event_t               res_event;
  logic                          res_last;

  logic                          in_xfer;
  logic [wsd_pkg::BYTE_W-1:0]    b;
  logic                          pend;
  logic [6:0]                    len7;
  logic [wsd_pkg::LIMIT_W:0]     next_count;

  assign in_s.ready = !out_valid_r || out_m.ready;
  assign in_xfer    = in_s.valid && in_s.ready;
  assign b          = in_s.byte_in;
  assign pend       = in_s.packet_end;
  assign len7       = b[6:0];
  assign next_count = {1'b0, frames_seen_r} + {{wsd_pkg::LIMIT_W{1'b0}}, 1'b1};

  assign cfg_s.ready = 1'b1;

  always_comb begin
    phase_nxt        = phase_r;
    packet_start_nxt = packet_start_r;
    len_left_nxt     = len_left_r;
    payload_left_nxt = payload_left_r;
    mask_word_nxt    = mask_word_r;
    mask_cnt_nxt     = mask_cnt_r;
    mask_pos_nxt     = mask_pos_r;
    frames_seen_nxt  = frames_seen_r;
    discarding_nxt   = discarding_r;
    res_vld          = 1'b0;
    res_byte         = '0;
    res_event        = wsd_pkg::EV_DATA;
    res_last         = 1'b0;

    if (!discarding_r) begin
      case (phase_r)
        wsd_pkg::PH_HDR0: begin
          if (packet_start_r && b == wsd_pkg::OPC_CLOSE) begin
            res_vld        = 1'b1;
            res_event      = wsd_pkg::EV_CLOSE;
            discarding_nxt = 1'b1;
          end else if (packet_start_r && b != wsd_pkg::OPC_TEXT && !b[1]) begin
            res_vld        = 1'b1;
            res_event      = wsd_pkg::EV_ERROR;
            discarding_nxt = 1'b1;
          end else begin
            phase_nxt = wsd_pkg::PH_LEN;
          end
          packet_start_nxt = 1'b0;
        end
        wsd_pkg::PH_LEN: begin
          mask_cnt_nxt = '0;
          if (len7 <= wsd_pkg::LEN_MAX_SHORT) begin
            payload_left_nxt = {{(wsd_pkg::LEN_W-7){1'b0}}, len7};
            phase_nxt        = wsd_pkg::PH_MASK;
          end else begin
            payload_left_nxt = '0;
            len_left_nxt     = (len7 == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                            : wsd_pkg::EXT64_BYTES;
            phase_nxt        = wsd_pkg::PH_EXT;
          end
        end
        wsd_pkg::PH_EXT: begin
          payload_left_nxt = {payload_left_r[wsd_pkg::LEN_W-wsd_pkg::BYTE_W-1:0], b};
          len_left_nxt     = len_left_r - 1'b1;
          if (len_left_r == {{(wsd_pkg::LEN_CNT_W-1){1'b0}}, 1'b1}) begin
            phase_nxt = wsd_pkg::PH_MASK;
          end
        end
        wsd_pkg::PH_MASK: begin
          mask_word_nxt[8*mask_cnt_r +: 8] = b;
          if (mask_cnt_r == 2'd3) begin
            if (next_count >= {1'b0, frame_limit_r}) begin
              res_vld        = 1'b1;
              res_event      = wsd_pkg::EV_ERROR;
              discarding_nxt = 1'b1;
            end else if (payload_left_r == '0) begin
              res_vld         = 1'b1;
              res_event       = wsd_pkg::EV_EMPTY;
              res_last        = 1'b1;
              frames_seen_nxt = next_count[wsd_pkg::FNUM_W-1:0];
              phase_nxt       = wsd_pkg::PH_HDR0;
            end else begin
              mask_pos_nxt = '0;
              phase_nxt    = wsd_pkg::PH_DATA;
            end
          end
          mask_cnt_nxt = mask_cnt_r + 2'd1;
        end
        wsd_pkg::PH_DATA: begin
          res_vld          = 1'b1;
          res_byte         = unmask_r ? (b ^ mask_word_r[8*mask_pos_r +: 8]) : b;
          mask_pos_nxt     = mask_pos_r + 2'd1;
          payload_left_nxt = payload_left_r - 1'b1;
          if (payload_left_r == {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1}) begin
            res_last        = 1'b1;
            frames_seen_nxt = next_count[wsd_pkg::FNUM_W-1:0];
            phase_nxt       = wsd_pkg::PH_HDR0;
          end else if (pend) begin
            res_event = wsd_pkg::EV_TRUNC;
            res_byte  = '0;
          end
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      endcase

      // Packet cut inside the first frame's header
      if (pend && !res_vld && phase_nxt != wsd_pkg::PH_HDR0 && frames_seen_r == '0) begin
        res_vld   = 1'b1;
        res_event = wsd_pkg::EV_TRUNC;
      end
    end

    // Packet end returns all per-packet state to its start values
    if (pend) begin
      phase_nxt        = wsd_pkg::PH_HDR0;
      packet_start_nxt = 1'b1;
      len_left_nxt     = '0;
      payload_left_nxt = '0;
      mask_cnt_nxt     = '0;
      mask_pos_nxt     = '0;
      frames_seen_nxt  = '0;
      discarding_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unmask_r      <= wsd_pkg::UNMASK_RST;
      frame_limit_r <= wsd_pkg::LIMIT_RST;
    end else if (cfg_s.valid && cfg_s.ready) begin
      if (cfg_s.index == wsd_pkg::REG_UNMASK) begin
        unmask_r <= cfg_s.data[0];
      end else if (cfg_s.index == wsd_pkg::REG_LIMIT) begin
        frame_limit_r <= cfg_s.data[wsd_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= wsd_pkg::PH_HDR0;
      packet_start_r <= 1'b1;
      len_left_r     <= '0;
      payload_left_r <= '0;
      mask_word_r    <= '0;
      mask_cnt_r     <= '0;
      mask_pos_r     <= '0;
      frames_seen_r  <= '0;
      discarding_r   <= 1'b0;
    end else if (in_xfer) begin
      phase_r        <= phase_nxt;
      packet_start_r <= packet_start_nxt;
      len_left_r     <= len_left_nxt;
      payload_left_r <= payload_left_nxt;
      mask_word_r    <= mask_word_nxt;
      mask_cnt_r     <= mask_cnt_nxt;
      mask_pos_r     <= mask_pos_nxt;
      frames_seen_r  <= frames_seen_nxt;
      discarding_r   <= discarding_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= res_vld;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load payload on every input transfer; a result-less byte leaves valid low
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_byte_r  <= res_byte;
      out_event_r <= res_event;
      out_last_r  <= res_last;
      out_fnum_r  <= frames_seen_r;
    end
  end

  assign out_m.valid        = out_valid_r;
  assign out_m.out_byte     = out_byte_r;
  assign out_m.event_res    = out_event_r;
  assign out_m.frame_last   = out_last_r;
  assign out_m.frame_number = out_fnum_r;

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("parser phase not one-hot");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |->
      (out_event_r == wsd_pkg::EV_DATA || out_event_r == wsd_pkg::EV_EMPTY))
    else $error("frame_last on a non-frame event");

  a_event_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r != wsd_pkg::EV_DATA |-> out_byte_r == '0)
    else $error("non-data event carries a byte");

  a_data_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wsd_pkg::PH_DATA |-> payload_left_r != '0)
    else $error("payload phase with zero bytes left");

  a_packet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && pend |=>
      (phase_r == wsd_pkg::PH_HDR0 && packet_start_r && !discarding_r &&
       frames_seen_r == '0))
    else $error("packet end did not clear parser state");

endmodule

// ----- tb/websocket_frame_deframer_core_test.sv -----
// Self-checking test for websocket_frame_deframer_core: random packets of masked frames
// are streamed in and every result is checked against a byte-level deframing predictor.
// Depends on wsd_pkg, the channel interfaces in wsd_ifs and the deframer core.

typedef struct {
  logic [wsd_pkg::BYTE_W-1:0] data;
  wsd_pkg::event_t            ev;
  logic                       last;
  logic [wsd_pkg::FNUM_W-1:0] fnum;
} deframed_t;

class deframer_scoreboard;
  bit                          unmask_on;
  bit [wsd_pkg::LIMIT_W-1:0]   limit;
  wsd_pkg::phase_t             ph;
  bit                          at_start;
  bit [wsd_pkg::LEN_CNT_W-1:0] len_left;
  bit [wsd_pkg::LEN_W-1:0]     pay_left;
  bit [31:0]                   mask_word;
  bit [1:0]                    mask_cnt;
  bit [1:0]                    mask_pos;
  bit [wsd_pkg::FNUM_W-1:0]    frames;
  bit                          dropping;
  deframed_t                   deframed_q[$];
  int                          mismatches;
  int                          parsed_bytes;
  int                          ev_count[5];

  function new();
    unmask_on = wsd_pkg::UNMASK_RST;
    limit     = wsd_pkg::LIMIT_RST;
    mask_word = '0;
    clear_packet();
  endfunction

  function void clear_packet();
    ph       = wsd_pkg::PH_HDR0;
    at_start = 1'b1;
    len_left = '0;
    pay_left = '0;
    mask_cnt = '0;
    mask_pos = '0;
    frames   = '0;
    dropping = 1'b0;
  endfunction

  function void apply_reg(logic [wsd_pkg::CFG_IDX_W-1:0] idx,
                          logic [wsd_pkg::CFG_DATA_W-1:0] val);
    if (idx == wsd_pkg::REG_UNMASK) unmask_on = val[0];
    else if (idx == wsd_pkg::REG_LIMIT) limit = val[wsd_pkg::LIMIT_W-1:0];
  endfunction

  function int pending();
    return deframed_q.size();
  endfunction

  function deframed_t blank();
    deframed_t r;
    r.data = '0;
    r.ev   = wsd_pkg::EV_DATA;
    r.last = 1'b0;
    r.fnum = '0;
    return r;
  endfunction

  // Advance the parser by one accepted byte and queue the result it owes.
  function void deframe_byte(logic [wsd_pkg::BYTE_W-1:0] b, logic e);
    deframed_t r;
    bit        owed;
    bit [6:0]  code;
    r      = blank();
    r.fnum = frames;
    owed   = 1'b0;
    if (!dropping) begin
      parsed_bytes++;
      case (ph)
        wsd_pkg::PH_HDR0: begin
          if (at_start && b == wsd_pkg::OPC_CLOSE) begin
            r.ev = wsd_pkg::EV_CLOSE; owed = 1'b1; dropping = 1'b1;
          end else if (at_start && b != wsd_pkg::OPC_TEXT && !b[1]) begin
            r.ev = wsd_pkg::EV_ERROR; owed = 1'b1; dropping = 1'b1;
          end else begin
            ph = wsd_pkg::PH_LEN;
          end
          at_start = 1'b0;
        end
        wsd_pkg::PH_LEN: begin
          code = b[6:0];
          mask_cnt = '0;
          if (code <= wsd_pkg::LEN_MAX_SHORT) begin
            pay_left = {{(wsd_pkg::LEN_W-7){1'b0}}, code};
            ph = wsd_pkg::PH_MASK;
          end else begin
            pay_left = '0;
            len_left = (code == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                    : wsd_pkg::EXT64_BYTES;
            ph = wsd_pkg::PH_EXT;
          end
        end
        wsd_pkg::PH_EXT: begin
          pay_left = {pay_left[wsd_pkg::LEN_W-9:0], b};
          len_left = len_left - 1'b1;
          if (len_left == 0) ph = wsd_pkg::PH_MASK;
        end
        wsd_pkg::PH_MASK: begin
          mask_word[8*mask_cnt +: 8] = b;
          if (mask_cnt == 2'd3) begin
            if ({1'b0, frames} + 5'd1 >= {1'b0, limit}) begin
              r.ev = wsd_pkg::EV_ERROR; owed = 1'b1; dropping = 1'b1;
            end else if (pay_left == 0) begin
              r.ev = wsd_pkg::EV_EMPTY; r.last = 1'b1; owed = 1'b1;
              frames = frames + 1'b1;
              ph = wsd_pkg::PH_HDR0;
            end else begin
              mask_pos = '0;
              ph = wsd_pkg::PH_DATA;
            end
          end
          mask_cnt = mask_cnt + 1'b1;
        end
        wsd_pkg::PH_DATA: begin
          r.data = unmask_on ? (b ^ mask_word[8*mask_pos +: 8]) : b;
          mask_pos = mask_pos + 1'b1;
          pay_left = pay_left - 1'b1;
          owed = 1'b1;
          if (pay_left == 0) begin
            r.last = 1'b1;
            frames = frames + 1'b1;
            ph = wsd_pkg::PH_HDR0;
          end else if (e) begin
            r.ev = wsd_pkg::EV_TRUNC; r.data = '0;
          end
        end
        default: ;
      endcase
      // a packet cut short inside the first frame's header is flagged, cuts in later headers are not
      if (e && !owed && ph != wsd_pkg::PH_HDR0 && r.fnum == 0) begin
        r.ev = wsd_pkg::EV_TRUNC; owed = 1'b1;
      end
    end
    if (e) clear_packet();
    if (owed) deframed_q.push_back(r);
  endfunction

  function void report(string what, deframed_t exp_r, deframed_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected byte %02h ev %0d last %0d frame %0d,",
               what, exp_r.data, exp_r.ev, exp_r.last, exp_r.fnum,
               "  got byte %02h ev %0d last %0d frame %0d",
               got.data, got.ev, got.last, got.fnum);
  endfunction

  function void check_result(deframed_t got);
    deframed_t exp_r;
    if (got.ev <= wsd_pkg::EV_TRUNC) ev_count[got.ev]++;
    if (deframed_q.size() == 0) begin
      exp_r = blank();
      report("unexpected result", exp_r, got);
      return;
    end
    exp_r = deframed_q.pop_front();
    if (got.data !== exp_r.data || got.ev !== exp_r.ev || got.last !== exp_r.last ||
        got.fnum !== exp_r.fnum)
      report("result mismatch", exp_r, got);
  endfunction

  function void flush_missing();
    deframed_t none;
    none = blank();
    while (deframed_q.size() != 0) report("missing result", deframed_q.pop_front(), none);
  endfunction
endclass

module websocket_frame_deframer_core_test;

  typedef enum int { ENC_SHORT, ENC_EXT16, ENC_EXT64 } len_enc_t;

  localparam logic [6:0]                 LEN_EXT64   = 7'd127;
  localparam logic [wsd_pkg::BYTE_W-1:0] MASK_FLAG   = 8'h80;
  localparam logic [wsd_pkg::BYTE_W-1:0] ACCEPT_BIT  = 8'h02;
  localparam int                         PHASES      = 6;
  localparam int                         PHASE_ITEMS = 70;

  logic clk;
  logic rst_n;
  bit   no_gaps;
  int   configs_run;
  int   sent_items;

  wsd_in_if  in_ch();
  wsd_out_if out_ch();
  wsd_cfg_if cfg_ch();

  deframer_scoreboard sb = new();

  websocket_frame_deframer_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch),
    .cfg_s (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    deframed_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.deframe_byte(in_ch.byte_in, in_ch.packet_end);
      if (out_ch.valid && out_ch.ready) begin
        got.data = out_ch.out_byte;
        got.ev   = out_ch.event_res;
        got.last = out_ch.frame_last;
        got.fnum = out_ch.frame_number;
        sb.check_result(got);
      end
    end
  end

  function automatic int pick_wait();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic send_byte(logic [wsd_pkg::BYTE_W-1:0] b, logic e);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_in    <= b;
    in_ch.packet_end <= e;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic send_packet(logic [wsd_pkg::BYTE_W-1:0] pkt[$]);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic result_sink();
    int stall;
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  endtask

  // Release the input and wait until every owed result has been checked.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [wsd_pkg::CFG_IDX_W-1:0] idx,
                           logic [wsd_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.apply_reg(idx, val);
  endtask

  task automatic add_frame(ref logic [wsd_pkg::BYTE_W-1:0] pkt[$],
                           input logic [wsd_pkg::BYTE_W-1:0] hdr, input len_enc_t enc,
                           input logic [wsd_pkg::LEN_W-1:0] dlen, input int nbytes);
    logic [wsd_pkg::BYTE_W-1:0] mk;
    mk = $urandom_range(0, 1) ? MASK_FLAG : 8'h00;
    pkt.push_back(hdr);
    case (enc)
      ENC_SHORT: pkt.push_back(mk | {1'b0, dlen[6:0]});
      ENC_EXT16: begin
        pkt.push_back(mk | {1'b0, wsd_pkg::LEN_EXT16});
        pkt.push_back(dlen[15:8]);
        pkt.push_back(dlen[7:0]);
      end
      default: begin
        pkt.push_back(mk | {1'b0, LEN_EXT64});
        for (int i = 7; i >= 0; i--) pkt.push_back(dlen[8*i +: 8]);
      end
    endcase
    repeat (4) pkt.push_back(8'($urandom));
    repeat (nbytes) pkt.push_back(8'($urandom));
  endtask

  task automatic add_random_frame(ref logic [wsd_pkg::BYTE_W-1:0] pkt[$],
                                  input logic [wsd_pkg::BYTE_W-1:0] hdr);
    int sel;
    int n;
    sel = $urandom_range(0, 19);
    if (sel < 10) begin
      n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      add_frame(pkt, hdr, ENC_SHORT, {32'd0, n}, n);
    end else if (sel == 10) begin
      n = $urandom_range(100, 125);
      add_frame(pkt, hdr, ENC_SHORT, {32'd0, n}, n);
    end else if (sel < 15) begin
      n = $urandom_range(0, 20);
      add_frame(pkt, hdr, ENC_EXT16, {32'd0, n}, n);
    end else if (sel == 15) begin
      n = $urandom_range(126, 300);
      add_frame(pkt, hdr, ENC_EXT16, {32'd0, n}, n);
    end else if (sel < 19) begin
      n = $urandom_range(0, 16);
      add_frame(pkt, hdr, ENC_EXT64, {32'd0, n}, n);
    end else begin
      // huge declared length: the packet always ends inside the payload
      add_frame(pkt, hdr, ENC_EXT64, {$urandom, $urandom}, $urandom_range(0, 6));
    end
  endtask

  task automatic send_random_packet();
    logic [wsd_pkg::BYTE_W-1:0] pkt[$];
    logic [wsd_pkg::BYTE_W-1:0] first;
    int                         nfr;
    int                         cut;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
    end else begin
      case ($urandom_range(0, 9))
        0:       first = wsd_pkg::OPC_CLOSE;
        1:       first = 8'($urandom) & ~ACCEPT_BIT;
        2, 3:    first = 8'($urandom) | ACCEPT_BIT;
        default: first = wsd_pkg::OPC_TEXT;
      endcase
      nfr = $urandom_range(0, 3) == 0 ? $urandom_range(1, sb.limit + 1) : $urandom_range(1, 3);
      for (int i = 0; i < nfr; i++) add_random_frame(pkt, i == 0 ? first : 8'($urandom));
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, pkt.size());
        pkt = pkt[0:cut-1];
      end
    end
    send_packet(pkt);
  endtask

  initial begin
    #2_000_000;
    $display("websocket_frame_deframer_core_test: FAIL");
    $finish;
  end

  initial begin
    logic [wsd_pkg::BYTE_W-1:0]     pkt[$];
    logic [wsd_pkg::CFG_DATA_W-1:0] unmask_plan[PHASES] = '{8'd0, 8'd1, 8'd1, 8'd0, 8'd1, 8'd1};
    logic [wsd_pkg::CFG_DATA_W-1:0] limit_plan[PHASES]  = '{8'd15, 8'd1, 8'd15, 8'd2, 8'd3, 8'd8};
    int                             start_items;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.byte_in    <= '0;
    in_ch.packet_end <= 1'b0;
    out_ch.ready     <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    fork
      result_sink();
    join_none

    // Directed: close, bad opcode, empty frame, data plus a trailing byte, cut header.
    send_packet('{wsd_pkg::OPC_CLOSE});
    send_packet('{8'h00});
    pkt = {};
    add_frame(pkt, wsd_pkg::OPC_TEXT, ENC_EXT16, 64'd0, 0);
    send_packet(pkt);
    pkt = {};
    add_frame(pkt, 8'h82, ENC_SHORT, 64'd2, 0);
    pkt.push_back(8'h00);
    pkt.push_back(8'hFF);
    pkt.push_back(wsd_pkg::OPC_TEXT);
    send_packet(pkt);
    send_packet('{8'hFF, 8'hFF});
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(wsd_pkg::REG_UNMASK, unmask_plan[p]);
      write_reg(wsd_pkg::REG_LIMIT, limit_plan[p]);
      configs_run++;
      no_gaps = (p == 2 || p == 4);
      start_items = sent_items;
      while (sent_items - start_items < PHASE_ITEMS) send_random_packet();
      settle();
    end

    sb.flush_missing();
    $display("Covered %0d bytes sent (%0d parsed) over %0d settings; results: %0d data,",
             sent_items, sb.parsed_bytes, configs_run + 1, sb.ev_count[wsd_pkg::EV_DATA]);
    $display("  %0d empty, %0d close, %0d error or limit, %0d truncated; %0d mismatches",
             sb.ev_count[wsd_pkg::EV_EMPTY], sb.ev_count[wsd_pkg::EV_CLOSE],
             sb.ev_count[wsd_pkg::EV_ERROR], sb.ev_count[wsd_pkg::EV_TRUNC], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("websocket_frame_deframer_core_test: PASS");
    end else begin
      $display("websocket_frame_deframer_core_test: FAIL");
    end
    $finish;
  end

endmodule
